// ===== src/chte_pkg.sv =====
package chte_pkg;

   localparam logic [1:0] CMD_INSERT = 2'd0;
   localparam logic [1:0] CMD_LOOKUP = 2'd1;
   localparam logic [1:0] CMD_REMOVE = 2'd2;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_MISSING = 2'd1;
   localparam logic [1:0] ST_FULL    = 2'd2;

   localparam logic [31:0] MIX_MUL_A = 32'h7feb352d;
   localparam logic [31:0] MIX_MUL_B = 32'h846ca68b;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [31:0] key;
      logic [31:0] handle_in;
   } req_item_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] handle_out;
   } rsp_item_type;

   typedef struct packed {
      logic       latch;
      logic [2:0] mix_step;
      logic       mix_en;
      logic       bucket_rd;
      logic       walk_start;
      logic       walk_step;
      logic       do_insert;
      logic       do_unlink;
      logic       rsp_load;
      logic [1:0] rsp_status;
      logic       rsp_hit;
   } dp_cmd_type;

   typedef struct packed {
      logic [1:0] cmd;
      logic       bucket_nonempty;
      logic       pool_empty;
      logic       match;
      logic       at_end;
      logic       step_limit;
      logic       rsp_busy;
      logic       init_busy;
      logic       reduce;
   } dp_status_type;

endpackage

// ===== src/chte_if.sv =====
interface chte_req_if;
   import chte_pkg::*;
   logic         valid;
   logic         ready;
   req_item_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface chte_rsp_if;
   import chte_pkg::*;
   logic         valid;
   logic         ready;
   rsp_item_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== src/chte_datapath.sv =====
module chte_datapath
   import chte_pkg::*;
#(
   parameter int BUCKETS = 64,
   parameter int ENTRIES = 256
) (
   input  logic          clock,
   input  logic          reset,
   input  req_item_type  req_item,
   input  dp_cmd_type    ctl,
   output dp_status_type sts,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output rsp_item_type  rsp_item
);

   localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
   localparam int EW = $clog2(ENTRIES);
   localparam int CW = $clog2(ENTRIES + 1);
   localparam bit POW2 = ((BUCKETS & (BUCKETS - 1)) == 0);
   localparam int RSH = 31 + BW;
   localparam logic [31:0] RECIP = 32'((64'd1 << RSH) / 64'(BUCKETS));

   logic [BW-1:0] bmask;
   assign bmask = BW'(BUCKETS - 1);

   req_item_type  item_ff;
   logic [31:0]   mix_ff, mix_in;
   logic [31:0]   quot_ff;
   logic [63:0]   quot_prod;
   logic [BW-1:0] bucket_ff;
   logic [BW-1:0] bucket_calc;

   logic          nonempty_ff [BUCKETS];
   logic [EW-1:0] head_mem [BUCKETS];
   logic [EW-1:0] tail_mem [BUCKETS];
   logic [31:0]   key_mem [ENTRIES];
   logic [31:0]   handle_mem [ENTRIES];
   logic [EW:0]   next_mem [ENTRIES];
   logic [EW-1:0] free_mem [ENTRIES];

   logic [CW-1:0] free_count_ff;
   logic [CW-1:0] init_ff;
   logic          init_done_ff;

   logic [EW-1:0] head_rd_ff, tail_rd_ff;
   logic [EW-1:0] cur_ff, prev_ff;
   logic          has_prev_ff;
   logic [CW-1:0] steps_ff;
   logic [31:0]   cur_key_ff, cur_handle_ff;
   logic [EW:0]   cur_next_ff;
   logic [EW-1:0] free_top_ff;
   logic [EW-1:0] rd_addr;

   logic          rsp_valid_ff;
   rsp_item_type  rsp_ff;

   assign quot_prod = {32'd0, mix_ff} * {32'd0, RECIP};

   always_comb begin
      mix_in = mix_ff;
      unique case (ctl.mix_step)
         3'd0: mix_in = item_ff.key ^ (item_ff.key >> 16);
         3'd1: mix_in = mix_ff * MIX_MUL_A;
         3'd2: mix_in = mix_ff ^ (mix_ff >> 15);
         3'd3: mix_in = mix_ff * MIX_MUL_B;
         3'd4: mix_in = mix_ff ^ (mix_ff >> 16);
         3'd5: mix_in = mix_ff;
         3'd6: mix_in = mix_ff - (quot_ff * 32'(BUCKETS));
         default: mix_in = mix_ff;
      endcase
   end

   always_comb begin
      if (POW2) begin
         bucket_calc = mix_ff[BW-1:0] & bmask;
      end else if (mix_ff >= 32'(BUCKETS)) begin
         bucket_calc = BW'(mix_ff - 32'(BUCKETS));
      end else begin
         bucket_calc = BW'(mix_ff);
      end
   end

   assign rd_addr = ctl.walk_start ? head_rd_ff : cur_next_ff[EW-1:0];

   always_ff @(posedge clock) begin
      if (ctl.latch) begin
         item_ff <= req_item;
      end
      if (ctl.mix_en) begin
         mix_ff <= mix_in;
      end
      if (ctl.mix_en && ctl.mix_step == 3'd5) begin
         quot_ff <= 32'(quot_prod >> RSH);
      end
      if (ctl.bucket_rd) begin
         bucket_ff  <= bucket_calc;
         head_rd_ff <= head_mem[bucket_calc];
         tail_rd_ff <= tail_mem[bucket_calc];
      end
      free_top_ff <= free_mem[EW'(free_count_ff - CW'(1))];
      if (ctl.walk_start || ctl.walk_step) begin
         cur_key_ff    <= key_mem[rd_addr];
         cur_handle_ff <= handle_mem[rd_addr];
         cur_next_ff   <= next_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (!init_done_ff) begin
         free_mem[init_ff[EW-1:0]] <= EW'(ENTRIES - 1) - init_ff[EW-1:0];
      end else if (ctl.do_insert) begin
         key_mem[free_top_ff]    <= item_ff.key;
         handle_mem[free_top_ff] <= item_ff.handle_in;
         next_mem[free_top_ff]   <= {1'b1, {EW{1'b0}}};
         if (nonempty_ff[bucket_ff]) begin
            next_mem[tail_rd_ff] <= {1'b0, free_top_ff};
         end else begin
            head_mem[bucket_ff] <= free_top_ff;
         end
         tail_mem[bucket_ff] <= free_top_ff;
      end else if (ctl.do_unlink) begin
         if (!has_prev_ff) begin
            if (!cur_next_ff[EW]) begin
               head_mem[bucket_ff] <= cur_next_ff[EW-1:0];
            end
         end else begin
            next_mem[prev_ff] <= cur_next_ff;
            if (cur_next_ff[EW]) begin
               tail_mem[bucket_ff] <= prev_ff;
            end
         end
         free_mem[free_count_ff[EW-1:0]] <= cur_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < BUCKETS; i++) begin
            nonempty_ff[i] <= 1'b0;
         end
         free_count_ff <= CW'(ENTRIES);
         init_ff       <= '0;
         init_done_ff  <= 1'b0;
      end else begin
         if (!init_done_ff) begin
            init_ff <= init_ff + CW'(1);
            if (init_ff == CW'(ENTRIES - 1)) begin
               init_done_ff <= 1'b1;
            end
         end
         if (ctl.do_insert) begin
            nonempty_ff[bucket_ff] <= 1'b1;
            free_count_ff <= free_count_ff - CW'(1);
         end else if (ctl.do_unlink) begin
            if (!has_prev_ff && cur_next_ff[EW]) begin
               nonempty_ff[bucket_ff] <= 1'b0;
            end
            free_count_ff <= free_count_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.walk_start) begin
         cur_ff      <= head_rd_ff;
         has_prev_ff <= 1'b0;
         steps_ff    <= CW'(1);
      end else if (ctl.walk_step) begin
         prev_ff     <= cur_ff;
         cur_ff      <= cur_next_ff[EW-1:0];
         has_prev_ff <= 1'b1;
         steps_ff    <= steps_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctl.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.rsp_load) begin
         rsp_ff.status     <= ctl.rsp_status;
         rsp_ff.handle_out <= ctl.rsp_hit ? cur_handle_ff : 32'd0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   assign sts.cmd             = item_ff.cmd;
   assign sts.bucket_nonempty = nonempty_ff[bucket_ff];
   assign sts.pool_empty      = (free_count_ff == '0);
   assign sts.match           = (cur_key_ff == item_ff.key);
   assign sts.at_end          = cur_next_ff[EW];
   assign sts.step_limit      = (steps_ff >= CW'(ENTRIES));
   assign sts.rsp_busy        = rsp_valid_ff && !rsp_ready;
   assign sts.init_busy       = !init_done_ff;
   assign sts.reduce          = POW2 ? 1'b0 : 1'b1;

endmodule

// ===== src/chte_control.sv =====
module chte_control
   import chte_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  dp_status_type sts,
   output dp_cmd_type    ctl
);

   typedef enum logic [7:0] {
      S_IDLE  = 8'b0000_0001,
      S_MIX   = 8'b0000_0010,
      S_BUCK  = 8'b0000_0100,
      S_DISP  = 8'b0000_1000,
      S_READ  = 8'b0001_0000,
      S_CHECK = 8'b0010_0000,
      S_DONE  = 8'b0100_0000,
      S_WAIT  = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;
   logic [2:0] step_ff, step_in;

   assign req_ready = (state_ff == S_IDLE) && !sts.init_busy;

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      ctl      = '0;
      ctl.mix_step = 3'd7;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && !sts.init_busy) begin
               ctl.latch = 1'b1;
               step_in   = 3'd0;
               state_in  = S_MIX;
            end
         end
         S_MIX: begin
            ctl.mix_en   = 1'b1;
            ctl.mix_step = step_ff;
            step_in      = step_ff + 3'd1;
            if ((step_ff == 3'd4 && !sts.reduce) || step_ff == 3'd6) begin
               state_in = S_BUCK;
            end
         end
         S_BUCK: begin
            ctl.bucket_rd = 1'b1;
            state_in      = S_DISP;
         end
         S_DISP: begin
            if (sts.rsp_busy) begin
               state_in = S_DISP;
            end else if (sts.cmd == CMD_INSERT) begin
               ctl.rsp_load   = 1'b1;
               ctl.rsp_status = sts.pool_empty ? ST_FULL : ST_OK;
               ctl.do_insert  = !sts.pool_empty;
               state_in       = S_IDLE;
            end else if ((sts.cmd == CMD_LOOKUP || sts.cmd == CMD_REMOVE)
                         && sts.bucket_nonempty) begin
               ctl.walk_start = 1'b1;
               state_in       = S_CHECK;
            end else begin
               ctl.rsp_load   = 1'b1;
               ctl.rsp_status = ST_MISSING;
               state_in       = S_IDLE;
            end
         end
         S_READ: begin
            ctl.walk_step = 1'b1;
            state_in      = S_CHECK;
         end
         S_CHECK: begin
            if (sts.match) begin
               state_in = S_DONE;
            end else if (sts.at_end || sts.step_limit) begin
               ctl.rsp_load   = 1'b1;
               ctl.rsp_status = ST_MISSING;
               state_in       = S_IDLE;
            end else begin
               state_in = S_READ;
            end
         end
         S_DONE: begin
            ctl.rsp_load   = 1'b1;
            ctl.rsp_status = ST_OK;
            ctl.rsp_hit    = 1'b1;
            ctl.do_unlink  = (sts.cmd == CMD_REMOVE);
            state_in       = S_WAIT;
         end
         S_WAIT: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

endmodule

// ===== src/chained_hash_table_engine_unit.sv =====
// Chained hash table engine: maps a 32-bit key to a 32-bit handle.
// The request channel carries one item per operation: cmd (insert, lookup,
// remove), key and handle_in. The response channel returns one item per
// request: status (ok, not found, pool full) and handle_out.
// A request is accepted only when the engine is idle, and one request is
// processed at a time. Hashing runs on the shared mixer (with a reduction
// modulo BUCKETS added when BUCKETS is not a power of two), followed by the
// bucket table read and dispatch; the response of an insert is registered
// at dispatch, and the engine then returns to idle for the next item.
// A lookup or remove then walks the bucket chain through the single read
// port of the entry pool, one entry at a time, until a match, the chain end
// or the step limit; a hit then passes a wait state before the engine is idle.
// After reset all buckets are empty; the free list is then rebuilt, during
// which the request channel is held not ready.
// The response sits in an output register. A stalled receiver holds it,
// and the engine may accept and hash the next item meanwhile, waiting
// before it would overwrite the held response.
module chained_hash_table_engine_unit
   import chte_pkg::*;
#(
   parameter int BUCKETS = 64,
   parameter int ENTRIES = 256
) (
   input logic    clock,
   input logic    reset,
   chte_req_if.sink   req,
   chte_rsp_if.source rsp
);

   dp_cmd_type    ctl;
   dp_status_type sts;

   chte_control u_control (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .sts       (sts),
      .ctl       (ctl)
   );

   chte_datapath #(
      .BUCKETS (BUCKETS),
      .ENTRIES (ENTRIES)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_item  (req.payload),
      .ctl       (ctl),
      .sts       (sts),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .rsp_item  (rsp.payload)
   );

endmodule
